// ===== rtl/core/tkft_pkg.sv =====
// Shared constants and types for the top-k frequency tracker.
// Used by the top level; depends on nothing.
`default_nettype none

package tkft_pkg;

    localparam int MAX_SLOTS    = 16;
    localparam int REPORT_LIMIT = 16;
    localparam int IDX_W        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SLOTS + 1);

    localparam int ID_W         = 16;
    localparam int COUNT_W      = 32;
    localparam int RANK_W       = 4;
    localparam int CFG_W        = 5;
    localparam int ENTRY_W      = ID_W + COUNT_W;

    localparam int IN_TDATA_W   = ((ID_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_W + COUNT_W + RANK_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int IN_PAD_W     = IN_TDATA_W - ENTRY_W;

    localparam logic KIND_OFFER  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/top_k_frequency_tracker_unit.sv =====
// Top level of the top-k frequency tracker: control sequencer, shared comparator
// and output register. Depends on tkft_pkg and tkft_ram.
//
// Usage: words arrive on the s_ channel. s_tuser selects the kind: an offer
// carries an entry id and its count, a report asks for the ranking. An offer
// is appended while fewer than k slots are filled; once full, the first slot
// with the smallest count among slots 0 to k-1 is replaced when the new count
// is strictly larger. A report sends every filled entry on the m_ channel in
// descending count order, ties to the lower slot, with tlast on the final word.
// k is set through the cfg_ port, which is always ready; the user must write
// it only while idle, as the block does not enforce this. An append finishes
// in the idle state. An offer to a full table walks the slot RAM read port once
// with the single comparator, then decides. A report walks the table once per
// rank, loading the output register after each walk.
// s_tready is high only when the sequencer is idle. When the receiver stalls,
// the finished word waits in the output register and the walk for the next
// rank continues; the sequencer holds before loading until that word is taken.
// Reset (synchronous, active low) empties the table and sets k to 16.
`default_nettype none

module top_k_frequency_tracker_unit
    import tkft_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // entry_id, entry_count
    input  wire logic                   s_tuser,  // kind

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,  // out_id, out_count, out_rank
    output logic                        m_tlast,  // out_last

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data   // slots_in_use
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       cfg_reg;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic                   kind_reg, kind_next;
    logic [ID_W-1:0]        in_id_reg, in_id_next;
    logic [COUNT_W-1:0]     in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       min_idx_reg, min_idx_next;
    logic [COUNT_W-1:0]     min_cnt_reg, min_cnt_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0]     best_cnt_reg, best_cnt_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [MAX_SLOTS-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]       rank_reg, rank_next;
    logic [CNT_W-1:0]       emit_reg, emit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                   s_fire;
    logic [CNT_W-1:0]       k_act;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;
    logic [ID_W-1:0]        rd_id;
    logic [COUNT_W-1:0]     rd_cnt;
    logic [COUNT_W-1:0]     cmp_a;
    logic [COUNT_W-1:0]     cmp_b;
    logic                   cmp_lt;
    logic                   issuing;
    logic                   scan_last;
    logic                   out_free;

    tkft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_id     = rd_data[ID_W-1:0];
    assign rd_cnt    = rd_data[ENTRY_W-1:ID_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign k_act     = (int'(cfg_reg) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_reg);
    assign issuing   = (state_reg == ST_SCAN) && (issue_reg < limit_reg);
    assign scan_last = cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + 1'b1) == limit_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // The one comparator of the block; operands follow the current step.
    always_comb begin
        unique case (state_reg)
            ST_DECIDE: begin
                cmp_a = min_cnt_reg;
                cmp_b = in_cnt_reg;
            end
            ST_SCAN: begin
                if (kind_reg == KIND_OFFER) begin
                    cmp_a = rd_cnt;
                    cmp_b = min_cnt_reg;
                end else begin
                    cmp_a = best_cnt_reg;
                    cmp_b = rd_cnt;
                end
            end
            default: begin
                cmp_a = min_cnt_reg;
                cmp_b = in_cnt_reg;
            end
        endcase
        cmp_lt = (cmp_a < cmp_b);
    end

    always_comb begin
        state_next      = state_reg;
        filled_next     = filled_reg;
        kind_next       = kind_reg;
        in_id_next      = in_id_reg;
        in_cnt_next     = in_cnt_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        min_idx_next    = min_idx_reg;
        min_cnt_next    = min_cnt_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_id_next    = best_id_reg;
        used_next       = used_reg;
        rank_next       = rank_reg;
        emit_next       = emit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        wr_en           = 1'b0;
        wr_addr         = filled_reg[IDX_W-1:0];
        wr_data         = s_tdata[ENTRY_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next   = s_tuser;
                    in_id_next  = s_tdata[ID_W-1:0];
                    in_cnt_next = s_tdata[ENTRY_W-1:ID_W];
                    issue_next  = '0;
                    if (s_tuser == KIND_OFFER) begin
                        if (k_act != '0) begin
                            if (filled_reg < k_act) begin
                                wr_en       = 1'b1;
                                filled_next = filled_reg + 1'b1;
                            end else begin
                                limit_next = k_act;
                                state_next = ST_SCAN;
                            end
                        end
                    end else if (filled_reg != '0) begin
                        limit_next      = filled_reg;
                        emit_next       = (int'(filled_reg) > REPORT_LIMIT) ?
                                          CNT_W'(REPORT_LIMIT) : filled_reg;
                        rank_next       = '0;
                        used_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issuing) begin
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg) begin
                    if (kind_reg == KIND_OFFER) begin
                        if (cmp_idx_reg == '0 || cmp_lt) begin
                            min_idx_next = cmp_idx_reg;
                            min_cnt_next = rd_cnt;
                        end
                    end else if (!used_reg[cmp_idx_reg] && (!best_found_reg || cmp_lt)) begin
                        best_found_next = 1'b1;
                        best_idx_next   = cmp_idx_reg;
                        best_cnt_next   = rd_cnt;
                        best_id_next    = rd_id;
                    end
                    if (scan_last) begin
                        state_next = (kind_reg == KIND_OFFER) ? ST_DECIDE : ST_EMIT;
                    end
                end
            end
            ST_DECIDE: begin
                if (cmp_lt) begin
                    wr_en   = 1'b1;
                    wr_addr = min_idx_reg;
                    wr_data = {in_cnt_reg, in_id_reg};
                end
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next           = 1'b1;
                    m_tdata_next            = {{OUT_PAD_W{1'b0}}, RANK_W'(rank_reg),
                                               best_cnt_reg, best_id_reg};
                    m_tlast_next            = (rank_reg + 1'b1) == emit_reg;
                    used_next[best_idx_reg] = 1'b1;
                    if ((rank_reg + 1'b1) == emit_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        rank_next       = rank_reg + 1'b1;
                        issue_next      = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_W'(MAX_SLOTS);
            filled_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            filled_reg   <= filled_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        in_id_reg      <= in_id_next;
        in_cnt_reg     <= in_cnt_next;
        limit_reg      <= limit_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        min_idx_reg    <= min_idx_next;
        min_cnt_reg    <= min_cnt_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_cnt_reg   <= best_cnt_next;
        best_id_reg    <= best_id_next;
        used_reg       <= used_next;
        rank_reg       <= rank_next;
        emit_reg       <= emit_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(filled_reg) <= MAX_SLOTS)
        else $error("fill count exceeds table depth");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("slot RAM written during a table walk");

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output word loaded outside the emit step");

    a_cmp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (CNT_W'(cmp_idx_reg) < limit_reg))
        else $error("compare index beyond the walk limit");

endmodule

`default_nettype wire

// ===== rtl/core/tkft_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the slot table; depends on nothing.
`default_nettype none

module tkft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire
